### sv/fixed_block_pool_allocator_macros.svh
// Assertion macros shared by the block pool allocator modules.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBPA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBPA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fbpa_pkg.sv
// Types and constants of the block pool allocator.
package fbpa_pkg;

  localparam int ADDR_W   = 32;
  localparam int BS_W     = 17;
  localparam int BIU_W    = 6;
  localparam int OWN_W    = 16;
  localparam int OIDX_W   = 5;
  localparam int OCNT_W   = 6;
  localparam int ST_W     = 3;
  localparam int CMD_W    = 2;
  localparam int REG_W    = 2;
  localparam int DIV_STEPS = 32;
  localparam int DCNT_W   = $clog2(DIV_STEPS);

  localparam logic [REG_W-1:0] REG_POOL_BASE     = 2'd0;
  localparam logic [REG_W-1:0] REG_BLOCK_SIZE    = 2'd1;
  localparam logic [REG_W-1:0] REG_POOL_SIZE     = 2'd2;
  localparam logic [REG_W-1:0] REG_BLOCKS_IN_USE = 2'd3;

  localparam logic [BS_W-1:0]  BLOCK_SIZE_RST    = 17'd64;
  localparam logic [BIU_W-1:0] BLOCKS_IN_USE_RST = 6'd32;
  localparam logic [OWN_W-1:0] OWNER_RST         = 16'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_FREE    = 3'd1,
    ST_NULL       = 3'd2,
    ST_RANGE      = 3'd3,
    ST_NOT_USED   = 3'd4,
    ST_MISALIGNED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load_in;
    logic find;
    logic mul;
    logic check;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic early_fail;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

### sv/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator top level.
// From accept to result: init and no-op go straight to execute; allocate finds a free
// block and multiplies its index by the block size; release checks the address and, if
// the null and range checks pass, runs the 32-step divider on the offset. One transaction
// at a time; the next is taken once the result is registered; an output stall delays it.
// Synchronous active-low reset: every block free, used count 0, next owner id 1.
module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fbpa_pkg::REG_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fbpa_pkg::CMD_W-1:0]    in_command,
  input  logic [fbpa_pkg::ADDR_W-1:0]   in_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fbpa_pkg::ST_W-1:0]     out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]   out_block_address,
  output logic [fbpa_pkg::OIDX_W-1:0]   out_block_index,
  output logic [fbpa_pkg::OWN_W-1:0]    out_owner_id,
  output logic [fbpa_pkg::OCNT_W-1:0]   out_used_count,
  output logic [fbpa_pkg::OCNT_W-1:0]   out_free_count
);
  import fbpa_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  fbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  fbpa_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_command),
    .in_address        (in_address),
    .cmd               (dp_cmd),
    .sts               (dp_sts),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_block_index   (out_block_index),
    .out_owner_id      (out_owner_id),
    .out_used_count    (out_used_count),
    .out_free_count    (out_free_count)
  );

endmodule

### sv/fbpa_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module fbpa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
  input  logic [fbpa_pkg::BS_W-1:0]   divisor,
  output logic                      done,
  output logic [fbpa_pkg::ADDR_W-1:0] quotient
);
  import fbpa_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BS_W-1:0]     rem_r, rem_nxt;
  logic [BS_W-1:0]     dsr_r, dsr_nxt;
  logic [ADDR_W-1:0]   quo_r, quo_nxt;
  logic [BS_W:0]       shifted;
  logic [BS_W+1:0]     diff;

  assign shifted = {rem_r, quo_r[ADDR_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (!diff[BS_W+1]) begin
        rem_nxt = diff[BS_W-1:0];
        quo_nxt = {quo_r[ADDR_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[BS_W-1:0];
        quo_nxt = {quo_r[ADDR_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DCNT_W'(1);
      if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/fbpa_dp.sv
// Datapath: configuration, block maps, counters, divider and result register.
`include "fixed_block_pool_allocator_macros.svh"
module fbpa_dp #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fbpa_pkg::REG_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_wdata,
  input  logic [fbpa_pkg::CMD_W-1:0]    in_command,
  input  logic [fbpa_pkg::ADDR_W-1:0]   in_address,
  input  fbpa_pkg::dp_cmd_t             cmd,
  output fbpa_pkg::dp_sts_t             sts,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [fbpa_pkg::ST_W-1:0]     out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]   out_block_address,
  output logic [fbpa_pkg::OIDX_W-1:0]   out_block_index,
  output logic [fbpa_pkg::OWN_W-1:0]    out_owner_id,
  output logic [fbpa_pkg::OCNT_W-1:0]   out_used_count,
  output logic [fbpa_pkg::OCNT_W-1:0]   out_free_count
);
  import fbpa_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int NW    = (CNT_W > BIU_W) ? CNT_W : BIU_W;
  localparam int XI    = (IDX_W > OIDX_W) ? IDX_W : OIDX_W;
  localparam int XC    = (CNT_W > OCNT_W) ? CNT_W : OCNT_W;
  localparam int PW    = IDX_W + BS_W;

  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [BS_W-1:0]       bs_r, bs_nxt;
  logic [ADDR_W-1:0]     psize_r, psize_nxt;
  logic [BIU_W-1:0]      biu_r, biu_nxt;

  cmd_t                  op_r;
  logic [ADDR_W-1:0]     addr_r;
  logic                  found_r;
  logic [IDX_W-1:0]      idx_r;
  logic [ADDR_W-1:0]     prod_r;
  status_t               early_st_r;

  logic [NUM_BLOCKS-1:0] in_use_r, in_use_nxt;
  logic [NUM_BLOCKS-1:0] avail_r, avail_nxt;
  logic [OWN_W-1:0]      owner_r, owner_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]      free_r, free_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_st_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [OIDX_W-1:0]     out_idx_r;
  logic [OWN_W-1:0]      out_own_r;
  logic [OCNT_W-1:0]     out_used_r;
  logic [OCNT_W-1:0]     out_free_r;

  logic [NUM_BLOCKS-1:0] free_vec;
  logic                  found_c;
  logic [IDX_W-1:0]      ffs_c;
  logic [PW-1:0]         prod_c;
  logic [NW-1:0]         n_w;
  logic [NUM_BLOCKS-1:0] avail_init;
  logic                  misal;
  logic [ADDR_W:0]       range_top;
  status_t               early_st_c;
  logic [ADDR_W-1:0]     offset;
  logic                  div_done;
  logic [ADDR_W-1:0]     quo;
  logic                  q_big;
  logic [IDX_W-1:0]      q_idx;
  status_t               st_c;
  logic [ADDR_W-1:0]     baddr_c;
  logic [IDX_W-1:0]      sel_idx;
  logic [OWN_W-1:0]      own_c;
  logic [XI-1:0]         oidx_w;
  logic [XC-1:0]         oused_w;
  logic [XC-1:0]         ofree_w;

  always_comb begin
    base_nxt  = base_r;
    bs_nxt    = bs_r;
    psize_nxt = psize_r;
    biu_nxt   = biu_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_POOL_BASE:     base_nxt  = cfg_wdata;
        REG_BLOCK_SIZE:    bs_nxt    = cfg_wdata[BS_W-1:0];
        REG_POOL_SIZE:     psize_nxt = cfg_wdata;
        REG_BLOCKS_IN_USE: biu_nxt   = cfg_wdata[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  assign free_vec = avail_r & ~in_use_r;

  always_comb begin
    found_c = 1'b0;
    ffs_c   = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found_c = 1'b1;
        ffs_c   = IDX_W'(i);
      end
    end
  end

  assign prod_c = PW'(idx_r) * PW'(bs_r);

  assign n_w = (NW'(biu_r) > NW'(NUM_BLOCKS)) ? NW'(NUM_BLOCKS) : NW'(biu_r);
  assign misal = (base_r[1:0] != 2'b00) || ((n_w > NW'(1)) && (bs_r[1:0] != 2'b00));

  always_comb begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      avail_init[i] = NW'(i) < n_w;
    end
  end

  assign range_top = {1'b0, base_r} + {1'b0, psize_r};

  always_comb begin
    priority if (addr_r == '0) begin
      early_st_c = ST_NULL;
    end else if ((addr_r < base_r) || ({1'b0, addr_r} >= range_top) || (bs_r == '0)) begin
      early_st_c = ST_RANGE;
    end else begin
      early_st_c = ST_OK;
    end
  end

  assign offset = addr_r - base_r;

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (offset),
    .divisor  (bs_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign q_big = quo >= ADDR_W'(NUM_BLOCKS);
  assign q_idx = quo[IDX_W-1:0];

  always_comb begin
    in_use_nxt = in_use_r;
    avail_nxt  = avail_r;
    owner_nxt  = owner_r;
    used_nxt   = used_r;
    free_nxt   = free_r;
    st_c       = ST_OK;
    baddr_c    = '0;
    sel_idx    = '0;
    own_c      = '0;
    unique case (op_r)
      CMD_INIT: begin
        avail_nxt  = avail_init;
        in_use_nxt = '0;
        used_nxt   = '0;
        free_nxt   = CNT_W'(n_w);
        st_c       = misal ? ST_MISALIGNED : ST_OK;
      end
      CMD_ALLOC: begin
        if (found_r) begin
          in_use_nxt[idx_r] = 1'b1;
          owner_nxt = owner_r + OWN_W'(1);
          used_nxt  = used_r + CNT_W'(1);
          if (free_r != '0) begin
            free_nxt = free_r - CNT_W'(1);
          end
          baddr_c = base_r + prod_r;
          sel_idx = idx_r;
          own_c   = owner_r;
        end else begin
          st_c = ST_NO_FREE;
        end
      end
      CMD_RELEASE: begin
        priority if (early_st_r != ST_OK) begin
          st_c = early_st_r;
        end else if (q_big) begin
          st_c = ST_RANGE;
        end else if (!in_use_r[q_idx]) begin
          st_c    = ST_NOT_USED;
          sel_idx = q_idx;
        end else begin
          in_use_nxt[q_idx] = 1'b0;
          if (used_r != '0) begin
            used_nxt = used_r - CNT_W'(1);
          end
          free_nxt = free_r + CNT_W'(1);
          sel_idx  = q_idx;
        end
      end
      CMD_NOP: ;
    endcase
  end

  assign oidx_w  = XI'(sel_idx);
  assign oused_w = XC'(used_nxt);
  assign ofree_w = XC'(free_nxt);

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.early_fail = early_st_c != ST_OK;
  assign sts.div_done   = div_done;

  always_comb begin
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      bs_r        <= BLOCK_SIZE_RST;
      psize_r     <= '0;
      biu_r       <= BLOCKS_IN_USE_RST;
      in_use_r    <= '0;
      avail_r     <= '1;
      owner_r     <= OWNER_RST;
      used_r      <= '0;
      free_r      <= CNT_W'(NUM_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      bs_r        <= bs_nxt;
      psize_r     <= psize_nxt;
      biu_r       <= biu_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.commit) begin
        in_use_r <= in_use_nxt;
        avail_r  <= avail_nxt;
        owner_r  <= owner_nxt;
        used_r   <= used_nxt;
        free_r   <= free_nxt;
      end
    end
    if (cmd.load_in) begin
      op_r   <= cmd_t'(in_command);
      addr_r <= in_address;
    end
    if (cmd.find) begin
      found_r <= found_c;
      idx_r   <= ffs_c;
    end
    if (cmd.mul) begin
      prod_r <= ADDR_W'(prod_c);
    end
    if (cmd.check) begin
      early_st_r <= early_st_c;
    end
    if (cmd.commit) begin
      out_st_r   <= st_c;
      out_addr_r <= baddr_c;
      out_idx_r  <= oidx_w[OIDX_W-1:0];
      out_own_r  <= own_c;
      out_used_r <= oused_w[OCNT_W-1:0];
      out_free_r <= ofree_w[OCNT_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_st_r;
  assign out_block_address = out_addr_r;
  assign out_block_index   = out_idx_r;
  assign out_owner_id      = out_own_r;
  assign out_used_count    = out_used_r;
  assign out_free_count    = out_free_r;

  `FBPA_ASSERT_IMP(a_count_bound, 1'b1,
                   ((CNT_W+1)'(used_r) + (CNT_W+1)'(free_r)) <= (CNT_W+1)'(NUM_BLOCKS),
                   "used plus free exceeds block count")
  `FBPA_ASSERT_NXT(a_commit_valid, cmd.commit, out_valid_r,
                   "commit did not raise out_valid")
  `FBPA_ASSERT_NXT(a_alloc_marks, cmd.commit && (op_r == CMD_ALLOC) && found_r,
                   in_use_r[idx_r], "allocated block not marked in use")

endmodule

### sv/fbpa_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
`include "fixed_block_pool_allocator_macros.svh"
module fbpa_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [fbpa_pkg::CMD_W-1:0] in_command,
  output logic                       in_stall,
  input  fbpa_pkg::dp_sts_t          sts,
  output fbpa_pkg::dp_cmd_t          cmd
);
  import fbpa_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(in_command))
            CMD_INIT:    state_nxt = S_EXEC;
            CMD_ALLOC:   state_nxt = S_FIND;
            CMD_RELEASE: state_nxt = S_CHECK;
            CMD_NOP:     state_nxt = S_EXEC;
          endcase
        end
      end
      S_FIND:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_EXEC;
      S_CHECK: state_nxt = sts.early_fail ? S_EXEC : S_DIV;
      S_DIV:   state_nxt = sts.div_done ? S_EXEC : S_DIV;
      S_EXEC:  state_nxt = sts.out_free ? S_IDLE : S_EXEC;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_FIND:  cmd.find = 1'b1;
      S_MUL:   cmd.mul  = 1'b1;
      S_CHECK: begin
        cmd.check     = 1'b1;
        cmd.div_start = !sts.early_fail;
      end
      S_DIV:   ;
      S_EXEC:  cmd.commit = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `FBPA_ASSERT_NXT(a_accept_stalls, in_valid && !in_stall, in_stall, "input not stalled after accept")
  `FBPA_ASSERT_NXT(a_commit_idle, cmd.commit, state_r == S_IDLE, "commit not followed by idle")
  `FBPA_ASSERT_IMP(a_done_in_div, sts.div_done, state_r == S_DIV, "divider done outside divide state")

endmodule
